@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the design files. Each macro expands to one
// labelled concurrent assertion on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge once reset has been released.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition causes a consequence in the next clock cycle.
`define MHPQ_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ design/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and types for the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;
  localparam int ENT_W       = KEY_W + PAY_W;
  localparam int CNT_W       = 8;
  localparam int CAPACITY    = STORE_DEPTH - 1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_ISS,
    S_UP_CHK,
    S_POP_LD,
    S_DN_ISS,
    S_DN_CHK,
    S_RESP
  } state_t;

endpackage

@@ design/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

@@ design/max_heap_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue over key and payload pairs, one RAM, one sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | input     | in_valid/in_stall  | cmd, key, payload
//  out_    | output    | out_valid/out_stall| accepted, popped/front key and payload,
//          |           |                    | count, empty_res, full_res
//
//  Sequence: a dropped push, an empty pop or a pop of the last item goes straight to the
//  response state; a push climbs level by level; a pop first loads the last entry, then
//  sinks it level by level. The heap holds up to 255 entries, and the sequencer returns
//  to idle before the next transaction. Each level is a RAM read, then a compare-and-write.
//  Reset: synchronous, active low; clears count, sequencer and output valid, not the RAM.
//  Stalls: input is taken whenever idle; a result blocked in the output register holds
//  the next one in the response state, which stalls the input.
//
`include "assert_macros.svh"

module max_heap_priority_queue_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [mhpq_pkg::KEY_W-1:0] in_key,
  input  logic [mhpq_pkg::PAY_W-1:0] in_payload,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_accepted,
  output logic [mhpq_pkg::KEY_W-1:0] out_popped_key,
  output logic [mhpq_pkg::PAY_W-1:0] out_popped_payload,
  output logic [mhpq_pkg::KEY_W-1:0] out_front_key,
  output logic [mhpq_pkg::PAY_W-1:0] out_front_payload,
  output logic [mhpq_pkg::CNT_W-1:0] out_count,
  output logic                       out_empty_res,
  output logic                       out_full_res
);

  import mhpq_pkg::*;

  // Sequencer and count
  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   count_r, count_nxt;

  // Item being sifted and the hole it is heading for
  logic [KEY_W-1:0]    item_key_r, item_key_nxt;
  logic [PAY_W-1:0]    item_pay_r, item_pay_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;

  // Result under construction
  logic                ok_r, ok_nxt;
  logic [KEY_W-1:0]    pk_r, pk_nxt;
  logic [PAY_W-1:0]    pp_r, pp_nxt;

  // Copy of heap entry 1, kept in step with every write to it
  logic [ENT_W-1:0]    root_r, root_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                res_ok_r;
  logic [KEY_W-1:0]    res_pk_r, res_fk_r;
  logic [PAY_W-1:0]    res_pp_r, res_fp_r;
  logic [ADDR_W-1:0]   res_cnt_r;

  // RAM port signals
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_ra, ram_rb;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata_a, ram_rdata_b;

  // Shared compare unit and index arithmetic
  logic                in_acc, out_free, res_load;
  logic [KEY_W-1:0]    ka, kb;
  logic [PAY_W-1:0]    pa, pb;
  logic [ADDR_W:0]     lc, rc;
  logic                pos_is_root, lc_past_end, rc_in_heap;
  logic                up_swap, a_gt, b_gt, pick_r, dn_swap;
  logic [ADDR_W-1:0]   big_idx;

  mhpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_ra),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_rb),
    .rdata_b (ram_rdata_b)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign res_load = (state_r == S_RESP) && out_free;

  // Split the read data: port A carries the parent, the last entry or the left child, port B the right child
  assign ka = ram_rdata_a[ENT_W-1:PAY_W];
  assign pa = ram_rdata_a[PAY_W-1:0];
  assign kb = ram_rdata_b[ENT_W-1:PAY_W];
  assign pb = ram_rdata_b[PAY_W-1:0];

  assign lc          = {pos_r, 1'b0};
  assign rc          = lc + 1'b1;
  assign pos_is_root = (pos_r == ADDR_W'(1));
  assign lc_past_end = (lc > {1'b0, count_r});
  assign rc_in_heap  = (rc <= {1'b0, count_r});

  // Climb while the item is strictly above its parent
  assign up_swap = (item_key_r > ka);
  // Right child wins only when strictly greater; swap only on a strictly greater child
  assign a_gt    = (ka > item_key_r);
  assign b_gt    = (kb > item_key_r);
  assign pick_r  = rc_in_heap && (kb > ka);
  assign dn_swap = pick_r ? b_gt : a_gt;
  assign big_idx = pick_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_PUSH) begin
            state_nxt = (count_r == ADDR_W'(CAPACITY)) ? S_RESP : S_UP_ISS;
          end else begin
            state_nxt = (count_r > ADDR_W'(1)) ? S_POP_LD : S_RESP;
          end
        end
      end
      S_UP_ISS: state_nxt = pos_is_root ? S_RESP : S_UP_CHK;
      S_UP_CHK: state_nxt = up_swap ? S_UP_ISS : S_RESP;
      S_POP_LD: state_nxt = S_DN_ISS;
      S_DN_ISS: state_nxt = lc_past_end ? S_RESP : S_DN_CHK;
      S_DN_CHK: state_nxt = dn_swap ? S_DN_ISS : S_RESP;
      S_RESP:   state_nxt = out_free ? S_IDLE : S_RESP;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    count_nxt    = count_r;
    item_key_nxt = item_key_r;
    item_pay_nxt = item_pay_r;
    pos_nxt      = pos_r;
    ok_nxt       = ok_r;
    pk_nxt       = pk_r;
    pp_nxt       = pp_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = {item_key_r, item_pay_r};
    ram_ra       = pos_r >> 1;
    ram_rb       = rc[ADDR_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ok_nxt = 1'b0;
          pk_nxt = '0;
          pp_nxt = '0;
          if (in_cmd == CMD_PUSH) begin
            // Append at count+1 and climb from there
            if (count_r != ADDR_W'(CAPACITY)) begin
              ok_nxt       = 1'b1;
              count_nxt    = count_r + 1'b1;
              pos_nxt      = count_r + 1'b1;
              item_key_nxt = in_key;
              item_pay_nxt = in_payload;
            end
          end else if (count_r != '0) begin
            // Hand out the root and fetch the last entry to refill it
            ok_nxt    = 1'b1;
            pk_nxt    = root_r[ENT_W-1:PAY_W];
            pp_nxt    = root_r[PAY_W-1:0];
            count_nxt = count_r - 1'b1;
            ram_ra    = count_r;
          end
        end
      end
      S_UP_ISS: begin
        if (pos_is_root) begin
          ram_we = 1'b1;
        end
      end
      S_UP_CHK: begin
        ram_we = 1'b1;
        if (up_swap) begin
          // Drop the parent into the hole and move up
          ram_wdata = ram_rdata_a;
          pos_nxt   = pos_r >> 1;
        end
      end
      S_POP_LD: begin
        item_key_nxt = ka;
        item_pay_nxt = pa;
        pos_nxt      = ADDR_W'(1);
      end
      S_DN_ISS: begin
        ram_ra = lc[ADDR_W-1:0];
        if (lc_past_end) begin
          ram_we = 1'b1;
        end
      end
      S_DN_CHK: begin
        ram_we = 1'b1;
        if (dn_swap) begin
          // Lift the larger child into the hole and move down
          ram_wdata = pick_r ? {kb, pb} : {ka, pa};
          pos_nxt   = big_idx;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign root_nxt = (ram_we && ram_waddr == ADDR_W'(1)) ? ram_wdata : root_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_key_r <= item_key_nxt;
    item_pay_r <= item_pay_nxt;
    pos_r      <= pos_nxt;
    ok_r       <= ok_nxt;
    pk_r       <= pk_nxt;
    pp_r       <= pp_nxt;
    root_r     <= root_nxt;
    if (res_load) begin
      res_ok_r  <= ok_r;
      res_pk_r  <= pk_r;
      res_pp_r  <= pp_r;
      res_fk_r  <= (count_r == '0) ? '0 : root_r[ENT_W-1:PAY_W];
      res_fp_r  <= (count_r == '0) ? '0 : root_r[PAY_W-1:0];
      res_cnt_r <= count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = res_ok_r;
  assign out_popped_key     = res_pk_r;
  assign out_popped_payload = res_pp_r;
  assign out_front_key      = res_fk_r;
  assign out_front_payload  = res_fp_r;
  assign out_count          = CNT_W'(res_cnt_r);
  assign out_empty_res      = (res_cnt_r == '0);
  assign out_full_res       = (res_cnt_r == ADDR_W'(CAPACITY));

  // Checks
  `MHPQ_ASSERT(a_count_range, count_r <= ADDR_W'(CAPACITY), "heap count beyond capacity")
  `MHPQ_ASSERT_NEXT(a_push_grows,
    in_acc && in_cmd == CMD_PUSH && count_r != ADDR_W'(CAPACITY),
    count_r == $past(count_r) + 1'b1, "accepted push did not grow the heap")
  `MHPQ_ASSERT(a_hole_nonzero,
    state_r == S_UP_ISS || state_r == S_UP_CHK || state_r == S_DN_ISS ||
    state_r == S_DN_CHK ? pos_r != '0 : 1'b1, "sift position reached entry zero")
  `MHPQ_ASSERT(a_write_bounds, ram_we |-> (ram_waddr != '0 && ram_waddr <= count_r),
    "heap write outside entries 1..count")

endmodule
